// File: hw/rtl/fpac_pkg.sv
package fpac_pkg;

	localparam int DW         = 32;
	// cordic x/y carry the rotation gain beyond 32 bits
	localparam int CW         = 35;
	localparam int ITERATIONS = 12;
	localparam int ITER_W     = $clog2(ITERATIONS + 1);
	// quotient of the small-angle path stays below 2^26
	localparam int DIV_STEPS  = 26;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic signed [DW-1:0] PI_FIX      = 32'sd1686629713;
	localparam logic signed [DW-1:0] HALF_PI_FIX = 32'sd843314856;
	localparam logic signed [DW-1:0] LIMIT32     = 32'sd2147483647;

	typedef struct packed {
		logic              load;
		logic              fold;
		logic              setup;
		logic              div_step;
		logic              cord_step;
		logic              finish;
		logic [ITER_W-1:0] idx;
	} fpac_cmd_t;

	typedef struct packed {
		logic axis;
		logic small_ang;
		logic y_zero;
	} fpac_stat_t;

	function automatic logic signed [DW-1:0] atan_entry(input logic [ITER_W-1:0] i);
		logic signed [DW-1:0] v;
		case (i)
			4'd0:    v = 32'sd421657428;
			4'd1:    v = 32'sd248918914;
			4'd2:    v = 32'sd131521918;
			4'd3:    v = 32'sd66762579;
			4'd4:    v = 32'sd33510843;
			4'd5:    v = 32'sd16771757;
			4'd6:    v = 32'sd8387925;
			4'd7:    v = 32'sd4194218;
			4'd8:    v = 32'sd2097141;
			4'd9:    v = 32'sd1048574;
			4'd10:   v = 32'sd524287;
			4'd11:   v = 32'sd262143;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/fixed_point_atan2_cordic_core.sv
// atan2 core: angle of the point (x, y) in radians scaled by 2^29, -pi to pi.
// input stream: s_axis_tdata carries y (bits 31:0) and x (bits 63:32), both
//   signed 32-bit; a transaction is taken when s_axis_tvalid and
//   s_axis_tready are both high.
// output stream: m_axis_tdata carries the signed 32-bit angle, one result per
//   input transaction, in order.
// one item is worked on at a time; s_axis_tready is high only while the
//   core is idle.
// path from input transaction to m_axis_tvalid, after the fold state:
//   axis points (x or y zero): straight to the finish state
//   flat angles (|x| >> 4 >= |y|): setup, then the 26-step restoring divider
//   other angles: setup, then n = 1..12 cordic steps, fewer once y hits zero
// the next input is taken the cycle after the result is written to the
//   output register, so the output may hold a result while the next item runs.
// if the receiver stalls, the result stays in the output register and the
//   next item waits in its final state until that register frees up.
// reset (arst_n low, asynchronous) returns to idle and drops m_axis_tvalid.
module fixed_point_atan2_cordic_core
	import fpac_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [2*DW-1:0] s_axis_tdata,  // y_value[31:0], x_value[63:32]
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [DW-1:0]   m_axis_tdata   // angle[31:0]
);

	fpac_cmd_t  cmd;
	fpac_stat_t st;

	fpac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	fpac_dpath u_dpath (
		.clk    (clk),
		.y_in   (s_axis_tdata[DW-1:0]),
		.x_in   (s_axis_tdata[2*DW-1:DW]),
		.cmd    (cmd),
		.st     (st),
		.result (m_axis_tdata)
	);

endmodule

// File: hw/rtl/fpac_dpath.sv
module fpac_dpath
	import fpac_pkg::*;
(
	input  logic                 clk,
	input  logic [DW-1:0]        y_in,
	input  logic [DW-1:0]        x_in,
	input  fpac_cmd_t            cmd,
	output fpac_stat_t           st,
	output logic [DW-1:0]        result
);

	logic signed [CW-1:0] x_q, y_q;
	logic signed [DW-1:0] acc_q;
	logic                 neg_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        res_q;

	logic signed [DW-1:0] y_sat, x_sat;
	logic signed [CW-1:0] sx, sy, x_nxt, y_nxt, xy_sum;
	logic signed [DW-1:0] tab, axis_val, acc_fin;
	logic [DW:0]          rem2, rem_sub;
	logic                 x_neg, y_neg, x_zero, y_zero_in;

	// most negative code is pulled into the symmetric range
	assign y_sat = (y_in == {1'b1, {(DW-1){1'b0}}}) ? -LIMIT32 : $signed(y_in);
	assign x_sat = (x_in == {1'b1, {(DW-1){1'b0}}}) ? -LIMIT32 : $signed(x_in);

	assign x_neg     = x_q[CW-1];
	assign y_neg     = y_q[CW-1];
	assign x_zero    = (x_q == '0);
	assign y_zero_in = (y_q == '0);

	always_comb begin
		if (x_zero) begin
			if (y_zero_in)
				axis_val = '0;
			else if (y_neg)
				axis_val = -HALF_PI_FIX;
			else
				axis_val = HALF_PI_FIX;
		end else if (x_neg) begin
			axis_val = PI_FIX;
		end else begin
			axis_val = '0;
		end
	end

	assign xy_sum = x_q + y_q;
	assign sx     = x_q >>> cmd.idx;
	assign sy     = y_q >>> cmd.idx;
	assign tab    = atan_entry(cmd.idx);

	always_comb begin
		if (y_neg) begin
			x_nxt = x_q - sy;
			y_nxt = y_q + sx;
		end else begin
			x_nxt = x_q + sy;
			y_nxt = y_q - sx;
		end
	end

	assign rem2    = {rem_q, 1'b0};
	assign rem_sub = rem2 - {2'b00, x_q[DW-2:0]};

	assign acc_fin = acc_q + $signed({{(DW-DIV_STEPS){1'b0}}, quo_q});

	assign st.axis      = x_zero | y_zero_in;
	assign st.small_ang = (x_q >>> 4) >= y_q;
	assign st.y_zero    = (y_nxt == '0);
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= CW'(x_sat);
			y_q <= CW'(y_sat);
		end else if (cmd.fold) begin
			quo_q <= '0;
			neg_q <= 1'b0;
			if (st.axis) begin
				acc_q <= axis_val;
			end else if (x_neg) begin
				x_q   <= -x_q;
				acc_q <= -PI_FIX;
				if (y_neg)
					y_q <= -y_q;
				else
					neg_q <= 1'b1;
			end else begin
				acc_q <= '0;
				if (y_neg) begin
					y_q   <= -y_q;
					neg_q <= 1'b1;
				end
			end
		end else if (cmd.setup) begin
			if (st.small_ang) begin
				// first remainder of (y << 29) / x, already below x
				rem_q <= {y_q[DW-4:0], 3'b000};
			end else if (xy_sum > CW'(LIMIT32)) begin
				x_q <= x_q >>> 1;
				y_q <= y_q >>> 1;
			end
		end else if (cmd.div_step) begin
			if (!rem_sub[DW]) begin
				rem_q <= rem_sub[DW-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q <= rem2[DW-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
		end else if (cmd.cord_step) begin
			x_q   <= x_nxt;
			y_q   <= y_nxt;
			acc_q <= y_neg ? (acc_q - tab) : (acc_q + tab);
		end
		if (cmd.finish)
			res_q <= neg_q ? -acc_fin : acc_fin;
	end

endmodule

// File: hw/rtl/fpac_ctrl.sv
module fpac_ctrl
	import fpac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  fpac_stat_t st,
	output fpac_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FOLD  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_CORD  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.idx       = cnt_q[ITER_W-1:0];
		cmd.load      = in_ready && in_valid;
		cmd.fold      = (state_q == ST_FOLD);
		cmd.setup     = (state_q == ST_SETUP);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.cord_step = (state_q == ST_CORD);
		cmd.finish    = (state_q == ST_FIN) && out_free;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_FOLD;
			ST_FOLD:  state_nxt = st.axis ? ST_FIN : ST_SETUP;
			ST_SETUP: state_nxt = st.small_ang ? ST_DIV : ST_CORD;
			ST_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_FIN;
			ST_CORD: begin
				// early exit once y lands on zero
				if (st.y_zero || cnt_q == CNT_W'(ITERATIONS - 1))
					state_nxt = ST_FIN;
			end
			ST_FIN:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV || state_q == ST_CORD)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
		else $error("divide step count out of range");
	a_cord_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORD) |-> (cnt_q < CNT_W'(ITERATIONS)))
		else $error("cordic step count out of range");
	a_load_fold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_FOLD))
		else $error("accepted transaction did not start folding");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");
`endif

endmodule

// File: verif/atan2_checker.sv
module atan2_checker
	import fpac_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  logic [2*DW-1:0] s_tdata,   // y_value[31:0], x_value[63:32]
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  logic [DW-1:0]   m_tdata,   // angle[31:0]
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PI_Q29      = 64'sd1686629713;
	localparam longint HALF_PI_Q29 = 64'sd843314856;
	localparam longint SYM_MAX     = 64'sd2147483647;
	localparam int     CORDIC_STEPS = 12;

	typedef struct {
		logic [DW-1:0] y;
		logic [DW-1:0] x;
		logic [DW-1:0] angle;
	} point_angle_t;

	longint arctan_q29 [CORDIC_STEPS] = '{
		421657428, 248918914, 131521918, 66762579, 33510843, 16771757,
		8387925, 4194218, 2097141, 1048574, 524287, 262143
	};

	point_angle_t angle_queue [$];
	int fail_count = 0;
	int fail_q = 0;
	int pending_q = 0;

	assign errors  = fail_q;
	assign pending = pending_q;

	function automatic logic [DW-1:0] predict_angle(input logic [DW-1:0] y_raw,
			input logic [DW-1:0] x_raw);
		longint y;
		longint x;
		longint acc;
		longint sx;
		longint sy;
		bit     negate;
		int     step;
		y = longint'($signed(y_raw));
		x = longint'($signed(x_raw));
		acc = 0;
		negate = 1'b0;
		// the most negative code is clipped to the symmetric range
		if (y < -SYM_MAX) y = -SYM_MAX;
		if (x < -SYM_MAX) x = -SYM_MAX;
		if (x == 0) begin
			if (y == 0) return '0;
			acc = (y < 0) ? -HALF_PI_Q29 : HALF_PI_Q29;
			return acc[DW-1:0];
		end
		if (y == 0) begin
			acc = (x < 0) ? PI_Q29 : 64'sd0;
			return acc[DW-1:0];
		end
		// fold into the first quadrant
		if (x < 0) begin
			x = -x;
			acc = -PI_Q29;
			if (y < 0) y = -y;
			else negate = 1'b1;
		end else if (y < 0) begin
			y = -y;
			negate = 1'b1;
		end
		if ((x >>> 4) >= y) begin
			acc += (y << 29) / x;
		end else begin
			if (x + y > SYM_MAX) begin
				x = x >>> 1;
				y = y >>> 1;
			end
			sx = x;
			sy = y;
			step = 0;
			while (step < CORDIC_STEPS) begin
				if (y < 0) begin
					x -= sy;
					y += sx;
					acc -= arctan_q29[step];
				end else begin
					x += sy;
					y -= sx;
					acc += arctan_q29[step];
				end
				if (y == 0) break;
				step++;
				sx = x >>> step;
				sy = y >>> step;
			end
		end
		if (negate) acc = -acc;
		return acc[DW-1:0];
	endfunction

	always @(posedge clk) begin
		point_angle_t head;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				head.y = s_tdata[DW-1:0];
				head.x = s_tdata[2*DW-1:DW];
				head.angle = predict_angle(head.y, head.x);
				angle_queue.push_back(head);
			end
			if (m_tvalid && m_tready) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: angle transaction with none expected: actual %0d",
						$time, $signed(m_tdata));
					fail_count++;
				end else begin
					head = angle_queue.pop_front();
					if (m_tdata !== head.angle) begin
						$display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, actual %0d",
							$time, $signed(head.y), $signed(head.x),
							$signed(head.angle), $signed(m_tdata));
						fail_count++;
					end
				end
			end
		end
		fail_q <= fail_count;
		pending_q <= angle_queue.size();
	end

endmodule

// File: verif/tb_top.sv
module tb_top
	import fpac_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [DW-1:0] POS_MAX  = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] NEG_MAX  = 32'h8000_0001;
	localparam logic [DW-1:0] NEG_CODE = 32'h8000_0000;
	localparam int RANDOM_POINTS = 1030;
	localparam int QUIET_TAIL    = 150;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [2*DW-1:0] s_axis_tdata = '0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [DW-1:0]   m_axis_tdata;

	int errors;
	int pending;
	int sent = 0;
	bit tail_quiet = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fixed_point_atan2_cordic_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	atan2_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// valid stays high across back-to-back items; it drops only for a gap and after the last item
	task automatic send_point(input logic [DW-1:0] y, input logic [DW-1:0] x);
		if (!tail_quiet && (sent % 200) >= 50 && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {x, y};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [DW-1:0] pick_extreme();
		logic [DW-1:0] v;
		case ($urandom_range(0, 5))
			0:       v = NEG_CODE;
			1:       v = NEG_MAX;
			2:       v = POS_MAX;
			3:       v = '0;
			4:       v = 32'd1;
			default: v = '1;
		endcase
		return v;
	endfunction

	function automatic logic [2*DW-1:0] random_point();
		logic [DW-1:0] y;
		logic [DW-1:0] x;
		logic [DW-1:0] mx;
		logic [DW-1:0] my;
		bit neg_x;
		bit neg_y;
		bit raw;
		neg_x = $urandom_range(0, 1);
		neg_y = $urandom_range(0, 1);
		mx = $urandom_range(1, 32'h7FFF_FFFF);
		my = $urandom_range(0, 32'h7FFF_FFFF);
		raw = 1'b0;
		y = '0;
		x = '0;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				x = $urandom;
				y = $urandom;
				raw = 1'b1;
			end
			// flat angles and the edge of the quotient path
			3: my = $urandom_range(0, mx >> 4);
			4: my = (mx >> 4) + $urandom_range(0, 2);
			5: begin
				mx = $urandom_range(0, 20);
				my = $urandom_range(0, 20);
			end
			6: if ($urandom_range(0, 1)) my = '0; else mx = '0;
			// near full scale, so the sum overflows and gets halved
			7: begin
				mx = POS_MAX - $urandom_range(0, 4096);
				my = POS_MAX - $urandom_range(0, 4096);
			end
			8: begin
				x = pick_extreme();
				y = pick_extreme();
				raw = 1'b1;
			end
			default: my = mx;
		endcase
		if (!raw) begin
			x = neg_x ? -mx : mx;
			y = neg_y ? -my : my;
		end
		return {x, y};
	endfunction

	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (tail_quiet) begin
				m_axis_tready <= 1'b1;
				@(negedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 40);
				m_axis_tready <= 1'b1;
				repeat (n) @(negedge clk);
			end
		end
	end

	initial begin
		logic [2*DW-1:0] pt;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// axes, origin and the clipped most negative code
		send_point(32'd0, 32'd0);
		send_point(32'd5, 32'd0);
		send_point(-32'd5, 32'd0);
		send_point(POS_MAX, 32'd0);
		send_point(NEG_CODE, 32'd0);
		send_point(32'd0, 32'd7);
		send_point(32'd0, -32'd7);
		send_point(32'd0, NEG_CODE);
		// full scale: sum overflow, diagonal stops after one step
		send_point(POS_MAX, POS_MAX);
		send_point(POS_MAX, NEG_MAX);
		send_point(NEG_CODE, NEG_CODE);
		send_point(NEG_MAX, POS_MAX);
		// quotient path and its boundary
		send_point(32'd1, 32'd16);
		send_point(32'd1, 32'd15);
		send_point(32'd2, 32'd31);
		send_point(32'd1, POS_MAX);
		send_point(-32'd1, POS_MAX);
		send_point(32'd1, NEG_MAX);
		// steep angles and the first three quadrants
		send_point(POS_MAX, 32'd1);
		send_point(POS_MAX, -32'd1);
		send_point(NEG_MAX, -32'd1);
		send_point(32'd3, 32'd4);
		send_point(-32'd3, -32'd4);
		send_point(32'd100, -32'd99);

		for (int i = 0; i < RANDOM_POINTS; i++) begin
			if (i == RANDOM_POINTS - QUIET_TAIL) tail_quiet = 1'b1;
			pt = random_point();
			send_point(pt[DW-1:0], pt[2*DW-1:DW]);
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
